[src/signed_binary_to_decimal_ascii_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the signed binary to decimal ASCII unit
// Concurrent checks clocked on the rising edge, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef SIGNED_BINARY_TO_DECIMAL_ASCII_UNIT_MACROS_SVH
`define SIGNED_BINARY_TO_DECIMAL_ASCII_UNIT_MACROS_SVH

// Same-cycle implication.
`define SBDA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SBDA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/sbda_pkg.sv]
// ----------------------------------------------------------------------------
// sbda_pkg
// Widths, character codes and the BCD correction step for the converter.
// ----------------------------------------------------------------------------
package sbda_pkg;

    localparam int IN_WIDTH    = 64;
    localparam int VALUE_WIDTH = 64;
    // Digits of 2^(VALUE_WIDTH-1): floor((W-1)*log10(2)) + 1
    localparam int NUM_DIGITS  = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
    localparam int DIGIT_W     = 4;
    localparam int BCD_W       = NUM_DIGITS * DIGIT_W;
    localparam int BIT_CNT_W   = $clog2(VALUE_WIDTH);
    localparam int DIG_CNT_W   = $clog2(NUM_DIGITS + 1);

    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_MINUS = 8'd45;

    // Add three to every BCD digit of five or more, ahead of a left shift.
    function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] bcd);
        logic [BCD_W-1:0]   res;
        logic [DIGIT_W-1:0] d;
        res = bcd;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            d = bcd[i*DIGIT_W +: DIGIT_W];
            if (d >= DIGIT_W'(5)) begin
                res[i*DIGIT_W +: DIGIT_W] = d + DIGIT_W'(3);
            end
        end
        return res;
    endfunction

endpackage

[src/signed_binary_to_decimal_ascii_unit.sv]
// Sequence: an accepted request is shifted into the BCD register bit by bit, leading
//   zero digits are skipped, then the '-' (if negative) and the digits are registered.
// Requests: a new one is taken only in idle, which is entered once the last character
//   has been loaded into the output register; a request gives 1 to 20 characters at 64 bits.
// Characters then leave at one per cycle when the consumer keeps ready high.
// Reset: synchronous active-low i_rst_n returns to idle and drops any pending character.
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_ascii_unit
// Converts a signed integer to decimal ASCII text, one character per output
// transfer, with a leading '-' for negatives and the last character flagged.
// ----------------------------------------------------------------------------
`include "signed_binary_to_decimal_ascii_unit_macros.svh"

module signed_binary_to_decimal_ascii_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // request channel
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [sbda_pkg::IN_WIDTH-1:0]  i_value,
    // character channel
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [7:0]                     o_char_code,
    output logic                           o_last
);
    import sbda_pkg::*;

    // One-hot sequencer:
    //   IDLE  wait for a request
    //   CONV  shift the magnitude into the BCD register, one bit per cycle
    //   SKIP  drop leading zero digits, one per cycle, keep at least one
    //   SIGN  emit '-' for a negative value
    //   EMIT  emit digits, most significant first
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CONV = 5'b00010,
        S_SKIP = 5'b00100,
        S_SIGN = 5'b01000,
        S_EMIT = 5'b10000
    } t_state;

    t_state                 r_state,    n_state;
    logic [VALUE_WIDTH-1:0] r_mag,      n_mag;
    logic [BCD_W-1:0]       r_bcd,      n_bcd;
    logic [BIT_CNT_W-1:0]   r_bit_cnt,  n_bit_cnt;
    logic [DIG_CNT_W-1:0]   r_dig_cnt,  n_dig_cnt;
    logic                   r_neg,      n_neg;
    logic                   r_out_valid, n_out_valid;
    logic [7:0]             r_char,     n_char;
    logic                   r_last,     n_last;

    logic [VALUE_WIDTH-1:0] in_bits;
    logic [DIGIT_W-1:0]     top_digit;
    logic [BCD_W-1:0]       bcd_adj;
    logic                   out_free;
    logic                   in_take;

    assign in_bits   = i_value[VALUE_WIDTH-1:0];
    assign top_digit = r_bcd[BCD_W-1 -: DIGIT_W];
    assign bcd_adj   = dabble(r_bcd);
    // The output register can take a new character when empty or draining.
    assign out_free  = !r_out_valid || i_out_ready;
    assign in_take   = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_mag       = r_mag;
        n_bcd       = r_bcd;
        n_bit_cnt   = r_bit_cnt;
        n_dig_cnt   = r_dig_cnt;
        n_neg       = r_neg;
        n_out_valid = r_out_valid && !i_out_ready;
        n_char      = r_char;
        n_last      = r_last;

        case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    // Magnitude as unsigned: the most negative value maps to 2^(W-1).
                    n_neg     = in_bits[VALUE_WIDTH-1];
                    n_mag     = in_bits[VALUE_WIDTH-1] ? VALUE_WIDTH'(~in_bits + 1'b1)
                                                       : in_bits;
                    n_bcd     = '0;
                    n_bit_cnt = BIT_CNT_W'(VALUE_WIDTH - 1);
                    n_state   = S_CONV;
                end
            end
            S_CONV: begin
                // Correct digits, then shift in the next magnitude bit.
                n_bcd     = {bcd_adj[BCD_W-2:0], r_mag[VALUE_WIDTH-1]};
                n_mag     = {r_mag[VALUE_WIDTH-2:0], 1'b0};
                n_bit_cnt = r_bit_cnt - 1'b1;
                if (r_bit_cnt == '0) begin
                    n_dig_cnt = DIG_CNT_W'(NUM_DIGITS);
                    n_state   = S_SKIP;
                end
            end
            S_SKIP: begin
                if (top_digit == '0 && r_dig_cnt != DIG_CNT_W'(1)) begin
                    n_bcd     = {r_bcd[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                    n_dig_cnt = r_dig_cnt - 1'b1;
                end else begin
                    n_state = r_neg ? S_SIGN : S_EMIT;
                end
            end
            S_SIGN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_char      = CHAR_MINUS;
                    n_last      = 1'b0;
                    n_state     = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_char      = CHAR_ZERO + {{(8-DIGIT_W){1'b0}}, top_digit};
                    n_last      = (r_dig_cnt == DIG_CNT_W'(1));
                    n_bcd       = {r_bcd[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                    n_dig_cnt   = r_dig_cnt - 1'b1;
                    if (r_dig_cnt == DIG_CNT_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state is reset; payload registers hold whatever they had.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag     <= n_mag;
        r_bcd     <= n_bcd;
        r_bit_cnt <= n_bit_cnt;
        r_dig_cnt <= n_dig_cnt;
        r_neg     <= n_neg;
        r_char    <= n_char;
        r_last    <= n_last;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_char_code = r_char;
    assign o_last      = r_last;

    // A request starts the bit-serial conversion and blocks further requests.
    `SBDA_ASSERT_NEXT(a_take_starts_conv, i_clk, i_rst_n, in_take, r_state == S_CONV && !o_in_ready, "request accepted but conversion did not start")
    // A minus sign never ends the text.
    `SBDA_ASSERT_IMPL(a_minus_not_last, i_clk, i_rst_n, o_out_valid && o_char_code == CHAR_MINUS, !o_last, "minus sign flagged as last character")
    // Every other character is a decimal digit.
    `SBDA_ASSERT_IMPL(a_digit_range, i_clk, i_rst_n, o_out_valid && o_char_code != CHAR_MINUS, o_char_code >= CHAR_ZERO && o_char_code <= CHAR_ZERO + 8'd9, "character is not a decimal digit")

endmodule

[test/signed_binary_to_decimal_ascii_unit_checker.sv]
// ----------------------------------------------------------------------------
// Decimal text checker
// Watches both channels of the converter, predicts the characters of every
// accepted request and compares each accepted character against them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module signed_binary_to_decimal_ascii_unit_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic [sbda_pkg::IN_WIDTH-1:0] i_value,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [7:0]                    i_char_code,
    input  logic                          i_last,
    output int                            o_fail_count,
    output int                            o_pending
);
    import sbda_pkg::*;

    // 2^63 has 19 digits; the conversion never produces more.
    localparam int MAX_DIGITS = 19;
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last;
    } t_text_char;

    t_text_char expected_text[$];

    // Append the decimal text of one request to the expected characters.
    function automatic void queue_decimal_text(input logic [IN_WIDTH-1:0] value);
        logic [63:0] mask;
        logic [63:0] x;
        logic [63:0] mag;
        logic [3:0]  digits[MAX_DIGITS];
        int          nd;
        logic        neg;
        mask = '1;
        mask = mask >> (64 - VALUE_WIDTH);
        x    = 64'(value) & mask;
        neg  = x[VALUE_WIDTH-1];
        // Unsigned magnitude keeps the most negative value exact.
        mag  = neg ? ((~x + 64'd1) & mask) : x;
        nd   = 0;
        do begin
            digits[nd] = 4'(mag % 64'd10);
            mag        = mag / 64'd10;
            nd++;
        end while (mag != 64'd0 && nd < MAX_DIGITS);
        if (neg) begin
            expected_text.push_back('{CHAR_MINUS, 1'b0});
        end
        for (int i = nd - 1; i >= 0; i--) begin
            expected_text.push_back('{CHAR_ZERO + 8'(digits[i]), (i == 0)});
        end
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        t_text_char want;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready) begin
                queue_decimal_text(i_value);
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_text.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= REPORT_MAX) begin
                        $display("%0t: unexpected char %0d last %0d", $realtime,
                                 i_char_code, i_last);
                    end
                end else begin
                    want = expected_text.pop_front();
                    if (want.char_code !== i_char_code || want.last !== i_last) begin
                        o_fail_count++;
                        if (o_fail_count <= REPORT_MAX) begin
                            $display("%0t: mismatch: expected char %0d last %0d, got char %0d last %0d",
                                     $realtime, want.char_code, want.last,
                                     i_char_code, i_last);
                        end
                    end
                end
            end
            o_pending = expected_text.size();
        end
    end

endmodule

[test/signed_binary_to_decimal_ascii_unit_test.sv]
// ----------------------------------------------------------------------------
// Signed binary to decimal ASCII unit testbench
// Sends directed and random 64-bit requests through several idle and stall
// phases; a checker beside the block predicts and compares every character.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module signed_binary_to_decimal_ascii_unit_test;

    import sbda_pkg::*;

    localparam int PHASE_ITEMS = 115;
    localparam int DRAIN_CYCLES = 120;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_ready;
    logic [IN_WIDTH-1:0] i_value     = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    logic [7:0]          o_char_code;
    logic                o_last;

    int fail_count;
    int pending_chars;

    // Percent chance, per cycle, that the sender idles or the receiver stalls.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    always #1 i_clk = ~i_clk;

    signed_binary_to_decimal_ascii_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_char_code (o_char_code),
        .o_last      (o_last)
    );

    signed_binary_to_decimal_ascii_unit_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_value      (i_value),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_char_code  (o_char_code),
        .i_last       (o_last),
        .o_fail_count (fail_count),
        .o_pending    (pending_chars)
    );

    // Receiver: decide ready once per cycle, on the falling edge.
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Offer one request. Enter and leave on a falling edge; valid stays high
    // on exit so a back-to-back request does not drop it for a step.
    task automatic send_request(input logic [IN_WIDTH-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_value    <= value;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    // Hold off the sender until every predicted character has arrived.
    task automatic wait_text_drained();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending_chars != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Pick a request: full-width noise, a random digit string, a power of
    // ten and its neighbors, or a small number; negate half the time.
    function automatic logic [IN_WIDTH-1:0] random_value();
        logic [63:0] v;
        int          ndig;
        int          k;
        case ($urandom_range(3))
            0: begin
                v = {$urandom, $urandom};
            end
            1: begin
                ndig = $urandom_range(1, 19);
                v = 64'($urandom_range(1, 9));
                for (int i = 1; i < ndig; i++) begin
                    v = v * 64'd10 + 64'($urandom_range(0, 9));
                end
            end
            2: begin
                k = $urandom_range(0, 18);
                v = 64'd1;
                for (int i = 0; i < k; i++) begin
                    v = v * 64'd10;
                end
                v = v + 64'($urandom_range(2)) - 64'd1;
            end
            default: begin
                v = 64'($urandom_range(0, 999));
            end
        endcase
        if ($urandom_range(1) == 1) begin
            v = -v;
        end
        return IN_WIDTH'(v);
    endfunction

    // Run time limit: far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        logic [IN_WIDTH-1:0] directed[$];

        // Hold reset, then release it on a falling edge.
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: zero, single digits, decade boundaries, both extremes.
        directed = '{
            64'd0, 64'd1, -64'sd1, 64'd9, -64'sd9, 64'd10, -64'sd10,
            64'd99, 64'd100, -64'sd100, 64'd999999999, -64'sd1000000000,
            64'd999999999999999999, 64'd1000000000000000000,
            -64'sd1000000000000000000, 64'h7fff_ffff_ffff_ffff,
            64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001,
            64'h7fff_ffff_ffff_fffe, 64'haaaa_aaaa_aaaa_aaaa,
            64'h5555_5555_5555_5555, 64'hffff_ffff_ffff_fff6
        };
        foreach (directed[i]) begin
            send_request(directed[i]);
        end
        wait_text_drained();

        // Random phases: no idling, sender idle, receiver stall, both.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 0;  recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 81; recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;  recv_stall_pct = 81;
                end
                default: begin
                    send_idle_pct = 34; recv_stall_pct = 34;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_request(random_value());
            end
            wait_text_drained();
        end

        // Let any stray character show up before the verdict.
        recv_stall_pct = 0;
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (fail_count == 0 && pending_chars == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
